>>> hw/rtl/fbk_pkg.sv
// Shared types and constants for the key filter and weight sort block.
package fbk_pkg;

	// Capacity of the record store
	localparam int MAX_RECORDS = 32;
	// Count holds 0..MAX_RECORDS, address holds 0..MAX_RECORDS-1
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int ADDR_W = $clog2(MAX_RECORDS);

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] category;
		logic [31:0] weight;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RD_I,
		ST_LD_I,
		ST_RD_J,
		ST_CMP,
		ST_EMIT
	} state_t;

endpackage

>>> hw/rtl/fbk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/filter_by_key_then_sort_by_weight_top.sv
// Top level: filter records by key, exchange-sort kept records by weight, emit in order.
//
//   channel   handshake                 payload
//   --------  ------------------------  ---------------------------------------------
//   request   start, busy               item_tag, category, weight, last_item
//   result    result_valid (strobe)     out_tag, out_category, out_weight,
//                                       none_found, overflowed, last_result
//   config    cfg_wr_en                 cfg_wr_data (match_key)
//
// Records load at one per cycle while busy is low. The record marked last starts
// the sort; each compare reads the record RAM through its one read port, then uses
// the shared weight comparator. Results leave one per pass, one cycle each; the
// receiver cannot stall them. Reset clears the count, the overflow mark and
// match_key; the RAM contents are not cleared and need no clearing pass.
module filter_by_key_then_sort_by_weight_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [15:0] item_tag,
	input  logic [15:0] category,
	input  logic [31:0] weight,
	input  logic        last_item,
	// result
	output logic        result_valid,
	output logic [15:0] out_tag,
	output logic [15:0] out_category,
	output logic [31:0] out_weight,
	output logic        none_found,
	output logic        overflowed,
	output logic        last_result
);

	import fbk_pkg::*;

	state_t state_q, state_d;

	logic [15:0]       match_key_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	rec_t              cur_q;

	logic              accept;
	logic              is_match;
	logic              has_room;
	logic              swap;
	logic              pass_last;
	logic              scan_end;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	rec_t              ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [REC_W-1:0]  ram_rdata;
	rec_t              rd_rec;

	logic              res_valid_q;
	rec_t              res_rec_q;
	logic              res_none_q;
	logic              res_ovf_q;
	logic              res_last_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign is_match  = (category == match_key_q);
	assign has_room  = (cnt_q < CNT_W'(MAX_RECORDS));
	assign rd_rec    = rec_t'(ram_rdata);
	// Shared comparator: later record swaps in on strictly smaller weight
	assign swap      = (cur_q.weight > rd_rec.weight);
	assign pass_last = ((i_q + CNT_W'(1)) == cnt_q);
	assign scan_end  = ((j_q + CNT_W'(1)) == cnt_q);

	// Record store
	fbk_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_RECORDS)
	) u_rec_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(REC_W'(ram_wdata)),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the load, the exchange passes and the emits; steer the RAM ports
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = '{tag: item_tag, category: category, weight: weight};
		ram_raddr = i_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_we = is_match && has_room;
					if (last_item) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				state_d = (cnt_q == '0) ? ST_IDLE : ST_RD_I;
			end
			ST_RD_I: begin
				ram_raddr = i_q[ADDR_W-1:0];
				state_d   = ST_LD_I;
			end
			ST_LD_I: begin
				state_d = pass_last ? ST_EMIT : ST_RD_J;
			end
			ST_RD_J: begin
				ram_raddr = j_q[ADDR_W-1:0];
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				// Park the held record at j when the later one wins
				ram_we    = swap;
				ram_waddr = j_q[ADDR_W-1:0];
				ram_wdata = cur_q;
				state_d   = scan_end ? ST_EMIT : ST_RD_J;
			end
			ST_EMIT: begin
				state_d = pass_last ? ST_IDLE : ST_RD_I;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Keep the key, the count, the overflow mark, the pass indices and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_key_q <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				match_key_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_match) begin
						if (has_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					i_q <= '0;
					if (cnt_q == '0) begin
						res_valid_q <= 1'b1;
						ovf_q       <= 1'b0;
					end
				end
				ST_LD_I: begin
					j_q <= i_q + CNT_W'(1);
				end
				ST_CMP: begin
					j_q <= j_q + CNT_W'(1);
				end
				ST_EMIT: begin
					res_valid_q <= 1'b1;
					if (pass_last) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the held record and load the result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				res_rec_q  <= '0;
				res_none_q <= 1'b1;
				res_ovf_q  <= ovf_q;
				res_last_q <= 1'b1;
			end
			ST_LD_I: begin
				cur_q <= rd_rec;
			end
			ST_CMP: begin
				if (swap) begin
					cur_q <= rd_rec;
				end
			end
			ST_EMIT: begin
				res_rec_q  <= cur_q;
				res_none_q <= 1'b0;
				res_ovf_q  <= ovf_q;
				res_last_q <= pass_last;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign out_tag      = res_rec_q.tag;
	assign out_category = res_rec_q.category;
	assign out_weight   = res_rec_q.weight;
	assign none_found   = res_none_q;
	assign overflowed   = res_ovf_q;
	assign last_result  = res_last_q;

`ifndef SYNTHESIS
	// Results only come out of a sort run
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a sort run");

	// An empty run gives one final result with zero payload
	a_none_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && none_found) |-> (last_result && out_weight == 32'd0 &&
			out_tag == 16'd0))
		else $error("malformed none-found result");

	// The last record of a set starts the sort
	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy)
		else $error("last record did not start the sort");

	// The store count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECORDS))
		else $error("kept count beyond capacity");
`endif

endmodule

>>> tb/fbk_sort_checker.sv
// Checker for the key filter and weight sort block: predicts each sorted run and compares results.
`timescale 1ns / 100ps

module fbk_sort_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] item_tag,
	input  logic [15:0] category,
	input  logic [31:0] weight,
	input  logic        last_item,
	input  logic        result_valid,
	input  logic [15:0] out_tag,
	input  logic [15:0] out_category,
	input  logic [31:0] out_weight,
	input  logic        none_found,
	input  logic        overflowed,
	input  logic        last_result,
	output int          mismatches,
	output int          outstanding
);

	import fbk_pkg::*;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] category;
		logic [31:0] weight;
		logic        none_found;
		logic        overflowed;
		logic        last_result;
	} sorted_out_t;

	// Shadow state of the block
	logic [15:0] key_now;
	rec_t        kept[MAX_RECORDS];
	int          kept_n;
	logic        dropped_match;

	sorted_out_t sorted_out_q[$];
	sorted_out_t want;
	int          errs;

	// Filter one request; on the last record, sort the kept set and queue its results
	task automatic keep_and_sort(input rec_t rec, input logic is_last);
		rec_t        swap;
		sorted_out_t res;
		int          i;
		int          j;
		if (rec.category == key_now) begin
			if (kept_n < MAX_RECORDS) begin
				kept[kept_n] = rec;
				kept_n++;
			end else begin
				dropped_match = 1'b1;
			end
		end
		if (!is_last)
			return;
		if (kept_n == 0) begin
			res = '0;
			res.none_found = 1'b1;
			res.overflowed = dropped_match;
			res.last_result = 1'b1;
			sorted_out_q.push_back(res);
		end else begin
			// Exchange sort: swap in a later record only on strictly smaller weight
			for (i = 0; i + 1 < kept_n; i++) begin
				for (j = i + 1; j < kept_n; j++) begin
					if (kept[i].weight > kept[j].weight) begin
						swap = kept[i];
						kept[i] = kept[j];
						kept[j] = swap;
					end
				end
			end
			for (i = 0; i < kept_n; i++) begin
				res.tag = kept[i].tag;
				res.category = kept[i].category;
				res.weight = kept[i].weight;
				res.none_found = 1'b0;
				res.overflowed = dropped_match;
				res.last_result = (i + 1 == kept_n);
				sorted_out_q.push_back(res);
			end
		end
		kept_n = 0;
		dropped_match = 1'b0;
	endtask

	function automatic int field_diff(input string field, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Track config writes and requests, then check any result in this cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_now = '0;
			kept_n = 0;
			dropped_match = 1'b0;
			sorted_out_q.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				key_now = cfg_wr_data;
			if (start && !busy)
				keep_and_sort(rec_t'({item_tag, category, weight}), last_item);
			if (result_valid) begin
				if (sorted_out_q.size() == 0) begin
					$error("result with no request pending: tag 0x%0h weight 0x%0h",
						out_tag, out_weight);
					errs++;
				end else begin
					want = sorted_out_q.pop_front();
					errs += field_diff("out_tag", 32'(want.tag), 32'(out_tag));
					errs += field_diff("out_category", 32'(want.category),
						32'(out_category));
					errs += field_diff("out_weight", want.weight, out_weight);
					errs += field_diff("none_found", 32'(want.none_found),
						32'(none_found));
					errs += field_diff("overflowed", 32'(want.overflowed),
						32'(overflowed));
					errs += field_diff("last_result", 32'(want.last_result),
						32'(last_result));
				end
			end
			mismatches <= errs;
			outstanding <= sorted_out_q.size();
		end
	end

endmodule

>>> tb/tb_filter_by_key_then_sort_by_weight_top.sv
// Testbench top: drives requests and key writes, watches for a stall, and reports the verdict.
`timescale 1ns / 100ps

module tb_filter_by_key_then_sort_by_weight_top;

	localparam int RANDOM_ITEMS = 360;
	localparam int CALM_TAIL    = 80;   // last requests go out with no gaps
	localparam int SETTLE       = 8;    // cycles after a run before touching the key
	localparam int DRAIN        = 50;
	localparam int STALL_LIMIT  = 5000;
	localparam int MAX_RUN_LO   = fbk_pkg::MAX_RECORDS + 2;
	localparam int MAX_RUN_HI   = fbk_pkg::MAX_RECORDS + 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        start;
	logic        busy;
	logic [15:0] item_tag;
	logic [15:0] category;
	logic [31:0] weight;
	logic        last_item;
	logic        result_valid;
	logic [15:0] out_tag;
	logic [15:0] out_category;
	logic [31:0] out_weight;
	logic        none_found;
	logic        overflowed;
	logic        last_result;

	int          mismatches;
	int          outstanding;
	logic [15:0] key_now;
	int          sent;
	bit          gaps_on;

	filter_by_key_then_sort_by_weight_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.item_tag    (item_tag),
		.category    (category),
		.weight      (weight),
		.last_item   (last_item),
		.result_valid(result_valid),
		.out_tag     (out_tag),
		.out_category(out_category),
		.out_weight  (out_weight),
		.none_found  (none_found),
		.overflowed  (overflowed),
		.last_result (last_result)
	);

	fbk_sort_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.item_tag    (item_tag),
		.category    (category),
		.weight      (weight),
		.last_item   (last_item),
		.result_valid(result_valid),
		.out_tag     (out_tag),
		.out_category(out_category),
		.out_weight  (out_weight),
		.none_found  (none_found),
		.overflowed  (overflowed),
		.last_result (last_result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Issue one request, with an optional idle burst ahead of it; hold until accepted
	task automatic send_record(input logic [15:0] tag, input logic [15:0] cat,
			input logic [31:0] w, input logic is_last);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		item_tag <= tag;
		category <= cat;
		weight <= w;
		last_item <= is_last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// Drop start, wait for every result of the run, then let the block settle
	task automatic finish_run();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_match_key(input logic [15:0] key);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= key;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		key_now = key;
	endtask

	// One set of records: mostly matches or near misses of the key, random weights
	task automatic random_run(input int len, input int match_pct, input bit ties);
		logic [15:0] cat;
		logic [31:0] w;
		int          i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < match_pct)
				cat = key_now;
			else if ($urandom_range(0, 1) == 0)
				cat = key_now ^ (16'h1 << $urandom_range(0, 15));
			else
				cat = 16'($urandom);
			if (ties)
				w = {14'd0, 2'($urandom_range(0, 3)), 16'h0000};
			else
				case ($urandom_range(0, 7))
					0: w = 32'h0000_0000;
					1: w = 32'hFFFF_FFFF;
					default: w = $urandom;
				endcase
			send_record(16'($urandom), cat, w, i == len - 1);
		end
		finish_run();
	endtask

	// Stimulus and verdict
	initial begin
		int len;
		int pct;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		start <= 1'b0;
		item_tag <= '0;
		category <= '0;
		weight <= '0;
		last_item <= 1'b0;
		key_now = '0;
		sent = 0;
		gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Key still at its reset value: extremes, equal weights, non-matching last record
		send_record(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
		send_record(16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
		send_record(16'h1234, 16'hFFFF, 32'h1234_5678, 1'b0);
		send_record(16'h0001, 16'h0000, 32'h0000_0000, 1'b0);
		send_record(16'h8000, 16'h0000, 32'h0001_0000, 1'b0);
		send_record(16'h7FFF, 16'h8000, 32'h0000_0000, 1'b1);
		finish_run();

		// Top key: a lone matching last record, then a set where nothing matches
		write_match_key(16'hFFFF);
		send_record(16'hAAAA, 16'hFFFF, 32'h8000_0000, 1'b1);
		finish_run();
		send_record(16'h5555, 16'hFFFE, 32'h7FFF_FFFF, 1'b1);
		finish_run();

		// Near-miss category and a matching last record that ties an earlier weight
		write_match_key(16'h5A5A);
		send_record(16'h0102, 16'h5A5A, 32'h0003_0000, 1'b0);
		send_record(16'h0203, 16'h5A5B, 32'h0000_8000, 1'b0);
		send_record(16'h0304, 16'h5A5A, 32'h0002_0000, 1'b0);
		send_record(16'h0405, 16'h5A5A, 32'h0003_0000, 1'b1);
		finish_run();

		// Random runs; some long enough to overflow the store
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = (sent < RANDOM_ITEMS - CALM_TAIL);
			if ($urandom_range(0, 2) == 0)
				case ($urandom_range(0, 3))
					0: write_match_key(16'h0000);
					1: write_match_key(16'hFFFF);
					default: write_match_key(16'($urandom));
				endcase
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(MAX_RUN_LO, MAX_RUN_HI);
				pct = 100;
			end else begin
				len = $urandom_range(1, 12);
				pct = $urandom_range(0, 100);
			end
			random_run(len, pct, $urandom_range(0, 3) == 0);
		end

		repeat (DRAIN) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_filter_by_key_then_sort_by_weight_top: PASS");
		else
			$display("tb_filter_by_key_then_sort_by_weight_top: FAIL");
		$finish;
	end

	// End the run if neither a request nor a result moves for too long
	initial begin : stall_watch
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || result_valid)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_filter_by_key_then_sort_by_weight_top: FAIL");
		$finish;
	end

endmodule
